// File: hw/rtl/cave_cellular_automaton_step_assert.svh
// ----------------------------------------------------------------------------
// Cave automaton step - assertion macros
// Shared forms for the concurrent checks; clocked on clk, off while arst_n low.
// ----------------------------------------------------------------------------
`ifndef CAVE_CELLULAR_AUTOMATON_STEP_ASSERT_SVH
`define CAVE_CELLULAR_AUTOMATON_STEP_ASSERT_SVH

// same-cycle implication
`define CCA_ASSERT_HOLDS(label, ante, cons, msg) \
	label: assert property (@(posedge clk) disable iff (!arst_n) (ante) |-> (cons)) \
		else $error(msg);

// next-cycle implication
`define CCA_ASSERT_NEXT(label, ante, cons, msg) \
	label: assert property (@(posedge clk) disable iff (!arst_n) (ante) |=> (cons)) \
		else $error(msg);

`endif

// File: hw/rtl/cca_pkg.sv
// ----------------------------------------------------------------------------
// Cave automaton step - package
// Fixed field widths, register indexes, reset values and helper functions.
// ----------------------------------------------------------------------------
`default_nettype none

package cca_pkg;

	localparam int unsigned COORD_W    = 11;
	localparam int unsigned CFG_W      = 12;
	localparam int unsigned MASK_W     = 9;
	localparam int unsigned CFG_IDX_W  = 2;
	localparam int unsigned NEIGH      = 8;
	localparam int unsigned CELL_LIMIT = 4194304;
	localparam int unsigned SIZE_MIN   = 3;
	localparam int unsigned SIZE_RST   = 64;

	localparam logic [MASK_W-1:0] BIRTH_RST    = 9'd448;
	localparam logic [MASK_W-1:0] SURVIVAL_RST = 9'd56;

	localparam logic [CFG_IDX_W-1:0] CFG_BIRTH    = 2'd0;
	localparam logic [CFG_IDX_W-1:0] CFG_SURVIVAL = 2'd1;
	localparam logic [CFG_IDX_W-1:0] CFG_WIDTH    = 2'd2;
	localparam logic [CFG_IDX_W-1:0] CFG_HEIGHT   = 2'd3;

	localparam int unsigned WIN_W = 6;
	// previous column top and bottom, column before that in full
	localparam logic [WIN_W-1:0] WIN_NEIGH_MASK = 6'h3D;

	localparam int unsigned COUNT_W = 4;

	typedef struct packed {
		logic bot;
		logic emit;
		logic last;
	} cell_ctl_t;

	function automatic int unsigned clamp_size(input logic [CFG_W-1:0] v,
		input int unsigned hi);
		int unsigned r;
		r = 32'(v);
		if (r < SIZE_MIN) r = SIZE_MIN;
		if (r > hi) r = hi;
		return r;
	endfunction

	function automatic logic [COUNT_W-1:0] count_ones(input logic [WIN_W-1:0] v);
		logic [COUNT_W-1:0] n;
		n = '0;
		for (int i = 0; i < WIN_W; i++) begin
			n = n + COUNT_W'(v[i]);
		end
		return n;
	endfunction

endpackage

`default_nettype wire

// File: hw/rtl/cca_cell_if.sv
// ----------------------------------------------------------------------------
// Cave automaton step - cell channel
// One grid cell per word, raster order.
// ----------------------------------------------------------------------------
`default_nettype none

interface cca_cell_if;
	logic valid;
	logic ready;
	logic cell_is_floor;

	modport source(output valid, output cell_is_floor, input ready);
	modport sink(input valid, input cell_is_floor, output ready);
endinterface

`default_nettype wire

// File: hw/rtl/cca_result_if.sv
// ----------------------------------------------------------------------------
// Cave automaton step - result channel
// One interior cell of the next generation per word.
// ----------------------------------------------------------------------------
`default_nettype none

interface cca_result_if;
	logic                          valid;
	logic                          ready;
	logic [cca_pkg::COORD_W-1:0]   out_x;
	logic [cca_pkg::COORD_W-1:0]   out_y;
	logic                          new_is_floor;
	logic                          last_cell;

	modport source(output valid, output out_x, output out_y, output new_is_floor,
		output last_cell, input ready);
	modport sink(input valid, input out_x, input out_y, input new_is_floor,
		input last_cell, output ready);
endinterface

`default_nettype wire

// File: hw/rtl/cca_front.sv
// ----------------------------------------------------------------------------
// Cave automaton step - front end
// Accepts cells, tracks raster position and classifies each cell.
// ----------------------------------------------------------------------------
`default_nettype none

module cca_front #(
	parameter int unsigned XW  = 11,
	parameter int unsigned YW  = 11,
	parameter int unsigned SWX = 12,
	parameter int unsigned SWY = 12
) (
	input  wire logic               clk,
	input  wire logic               arst_n,
	cca_cell_if.sink                grid,
	input  wire logic               restart,
	input  wire logic [SWX-1:0]     width,
	input  wire logic [SWY-1:0]     height,
	input  wire logic               full,
	output logic                    push,
	output logic [XW-1:0]           push_x,
	output logic [YW-1:0]           push_y,
	output cca_pkg::cell_ctl_t      push_ctl
);

	localparam int unsigned PW = SWX + SWY;

	logic [XW-1:0] col_q;
	logic [YW-1:0] row_q;
	logic [XW-1:0] x;
	logic [YW-1:0] y;
	logic          x_last;
	logic          y_last;
	logic          boundary;
	logic [PW-1:0] cells;
	logic          size_ok;

	assign x = (SWX'(col_q) >= width) ? '0 : col_q;
	assign y = (SWY'(row_q) >= height) ? '0 : row_q;

	assign x_last   = (SWX'(x) == width - SWX'(1));
	assign y_last   = (SWY'(y) == height - SWY'(1));
	assign boundary = (x == '0) || x_last || (y == '0) || y_last;

	assign cells   = PW'(width) * PW'(height);
	assign size_ok = (32'(cells) <= cca_pkg::CELL_LIMIT);

	assign grid.ready = !full;
	assign push       = grid.valid && !full;

	assign push_x        = x;
	assign push_y        = y;
	assign push_ctl.bot  = boundary ? 1'b0 : grid.cell_is_floor;
	assign push_ctl.emit = (x >= XW'(2)) && (y >= YW'(2)) && size_ok;
	assign push_ctl.last = x_last && y_last;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			col_q <= '0;
			row_q <= '0;
		end else if (restart) begin
			col_q <= '0;
			row_q <= '0;
		end else if (push) begin
			if (x_last) begin
				col_q <= '0;
				row_q <= y_last ? '0 : y + YW'(1);
			end else begin
				col_q <= x + XW'(1);
				row_q <= y;
			end
		end
	end

endmodule

`default_nettype wire

// File: hw/rtl/cca_queue.sv
// ----------------------------------------------------------------------------
// Cave automaton step - classified cell queue
// Two-entry FIFO between front and back end.
// ----------------------------------------------------------------------------
`default_nettype none

module cca_queue #(
	parameter int unsigned DATA_W = 24
) (
	input  wire logic              clk,
	input  wire logic              arst_n,
	input  wire logic              push,
	input  wire logic [DATA_W-1:0] push_data,
	output logic                   full,
	input  wire logic              pop,
	output logic [DATA_W-1:0]      pop_data,
	output logic                   empty
);

	logic [DATA_W-1:0] entry_q [2];
	logic              wr_ptr_q;
	logic              rd_ptr_q;
	logic [1:0]        count_q;

	assign full     = (count_q == 2'd2);
	assign empty    = (count_q == 2'd0);
	assign pop_data = entry_q[rd_ptr_q];

	always_ff @(posedge clk) begin
		if (push) begin
			entry_q[wr_ptr_q] <= push_data;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			wr_ptr_q <= 1'b0;
			rd_ptr_q <= 1'b0;
			count_q  <= 2'd0;
		end else begin
			if (push) begin
				wr_ptr_q <= !wr_ptr_q;
			end
			if (pop) begin
				rd_ptr_q <= !rd_ptr_q;
			end
			if (push && !pop) begin
				count_q <= count_q + 2'd1;
			end else if (pop && !push) begin
				count_q <= count_q - 2'd1;
			end
		end
	end

endmodule

`default_nettype wire

// File: hw/rtl/cca_back.sv
// ----------------------------------------------------------------------------
// Cave automaton step - back end
// Line buffer, 3x3 window, neighbour count, rule lookup and output register.
// ----------------------------------------------------------------------------
`default_nettype none

`include "cave_cellular_automaton_step_assert.svh"

module cca_back #(
	parameter int unsigned MAX_WIDTH = 2048,
	parameter int unsigned XW        = 11,
	parameter int unsigned YW        = 11
) (
	input  wire logic                          clk,
	input  wire logic                          arst_n,
	input  wire logic                          restart,
	input  wire logic [cca_pkg::MASK_W-1:0]    birth_mask,
	input  wire logic [cca_pkg::MASK_W-1:0]    survival_mask,
	input  wire logic                          q_valid,
	input  wire logic [XW-1:0]                 q_x,
	input  wire logic [YW-1:0]                 q_y,
	input  wire cca_pkg::cell_ctl_t            q_ctl,
	output logic                               pop,
	cca_result_if.source                       result
);

	// per column: bit 1 row two above, bit 0 row above
	logic [1:0] rows_mem [MAX_WIDTH];

	logic                             s1_valid_q;
	logic [XW-1:0]                    x_s1;
	logic [YW-1:0]                    y_s1;
	cca_pkg::cell_ctl_t               ctl_s1;
	logic [1:0]                       rd_s1;

	logic [cca_pkg::WIN_W-1:0]        win_q;
	logic                             res_valid_q;
	logic [cca_pkg::COORD_W-1:0]      res_x_q;
	logic [cca_pkg::COORD_W-1:0]      res_y_q;
	logic                             res_floor_q;
	logic                             res_last_q;

	logic                             out_free;
	logic                             s1_adv;
	logic                             s1_load;
	logic [2:0]                       cur;
	logic [cca_pkg::COUNT_W-1:0]      floors;
	logic [cca_pkg::COUNT_W-1:0]      walls;
	logic                             hit;

	assign out_free = !res_valid_q || result.ready;
	assign s1_adv   = s1_valid_q && (!ctl_s1.emit || out_free);
	assign s1_load  = q_valid && (!s1_valid_q || s1_adv);
	assign pop      = s1_load;

	assign cur    = {ctl_s1.bot, rd_s1[0], rd_s1[1]};
	assign floors = cca_pkg::count_ones(win_q & cca_pkg::WIN_NEIGH_MASK)
		+ cca_pkg::count_ones({3'b000, cur});
	assign walls  = cca_pkg::COUNT_W'(cca_pkg::NEIGH) - floors;
	assign hit    = win_q[1] ? birth_mask[walls] : survival_mask[walls];

	always_ff @(posedge clk) begin
		if (s1_load) begin
			rd_s1 <= rows_mem[q_x];
		end
		if (s1_adv) begin
			rows_mem[x_s1] <= {rd_s1[0], ctl_s1.bot};
		end
	end

	always_ff @(posedge clk) begin
		if (s1_load) begin
			x_s1   <= q_x;
			y_s1   <= q_y;
			ctl_s1 <= q_ctl;
		end
		if (s1_adv && ctl_s1.emit) begin
			res_x_q     <= cca_pkg::COORD_W'(x_s1 - XW'(1));
			res_y_q     <= cca_pkg::COORD_W'(y_s1 - YW'(1));
			res_floor_q <= !hit;
			res_last_q  <= ctl_s1.last;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			s1_valid_q  <= 1'b0;
			res_valid_q <= 1'b0;
			win_q       <= '0;
		end else begin
			if (s1_load) begin
				s1_valid_q <= 1'b1;
			end else if (s1_adv) begin
				s1_valid_q <= 1'b0;
			end
			if (s1_adv && ctl_s1.emit) begin
				res_valid_q <= 1'b1;
			end else if (result.ready) begin
				res_valid_q <= 1'b0;
			end
			if (restart) begin
				win_q <= '0;
			end else if (s1_adv) begin
				win_q <= {win_q[2:0], cur};
			end
		end
	end

	assign result.valid        = res_valid_q;
	assign result.out_x        = res_x_q;
	assign result.out_y        = res_y_q;
	assign result.new_is_floor = res_floor_q;
	assign result.last_cell    = res_last_q;

	`CCA_ASSERT_NEXT(a_emit_loads_output, s1_adv && ctl_s1.emit, res_valid_q, "result word dropped")
	`CCA_ASSERT_NEXT(a_stall_holds_cell, s1_valid_q && !s1_adv, s1_valid_q && $stable(x_s1), "stalled cell lost")
	`CCA_ASSERT_NEXT(a_restart_clears_window, restart, win_q == '0, "window not cleared on restart")
	`CCA_ASSERT_HOLDS(a_pop_only_valid, pop, q_valid, "pop from empty queue")

endmodule

`default_nettype wire

// File: hw/rtl/cave_cellular_automaton_step.sv
// ----------------------------------------------------------------------------
// Cave cellular automaton step - top level
// Usage:
//  Feed the grid on "grid", one cell_is_floor word per cycle in raster order
//  (row 0 first, column 0 first). The block returns the next generation of
//  every interior cell on "result"; boundary cells give no word. The result
//  for interior cell (x, y) follows the input of cell (x + 1, y + 1), so one
//  pass of W x H cells yields (W - 2) x (H - 2) words, last_cell marking the
//  final one. Run further passes for further generations.
//  Throughput: one cell per cycle while result.ready stays high, set by the
//  single line buffer port pair (one read and one write per cell). Path: the
//  completing cell passes the queue, stage 1 and the output register.
//  Configuration: cfg_we / cfg_index / cfg_data write birth_mask,
//  survival_mask, grid_width, grid_height; a size write restarts the pass.
//  Write only while the block is idle.
//  Reset: masks and sizes return to their defaults, the pass restarts at row
//  0. The line buffer needs no clearing: rows 0 and 1 rewrite it first.
//  Stall: while result.ready is low the output word holds, the back end holds
//  one cell, the two-entry queue fills and then grid.ready drops.
// ----------------------------------------------------------------------------
`default_nettype none

module cave_cellular_automaton_step #(
	parameter int unsigned MAX_WIDTH  = 2048,
	parameter int unsigned MAX_HEIGHT = 2048
) (
	input  wire logic                           clk,
	input  wire logic                           arst_n,
	cca_cell_if.sink                            grid,
	cca_result_if.source                        result,
	input  wire logic                           cfg_we,
	input  wire logic [cca_pkg::CFG_IDX_W-1:0]  cfg_index,
	input  wire logic [cca_pkg::CFG_W-1:0]      cfg_data
);

	localparam int unsigned XW  = $clog2(MAX_WIDTH);
	localparam int unsigned YW  = $clog2(MAX_HEIGHT);
	localparam int unsigned SWX = $clog2(MAX_WIDTH + 1);
	localparam int unsigned SWY = $clog2(MAX_HEIGHT + 1);
	localparam int unsigned QW  = 3 + XW + YW;
	localparam int unsigned W_RST =
		(cca_pkg::SIZE_RST > MAX_WIDTH) ? MAX_WIDTH : cca_pkg::SIZE_RST;
	localparam int unsigned H_RST =
		(cca_pkg::SIZE_RST > MAX_HEIGHT) ? MAX_HEIGHT : cca_pkg::SIZE_RST;

	logic [cca_pkg::MASK_W-1:0] birth_q;
	logic [cca_pkg::MASK_W-1:0] survival_q;
	logic [SWX-1:0]             width_q;
	logic [SWY-1:0]             height_q;
	logic                       restart;

	logic                       q_full;
	logic                       q_empty;
	logic                       q_pop;
	logic                       push;
	logic [XW-1:0]              push_x;
	logic [YW-1:0]              push_y;
	cca_pkg::cell_ctl_t         push_ctl;
	logic [QW-1:0]              q_data;
	logic [XW-1:0]              q_x;
	logic [YW-1:0]              q_y;
	cca_pkg::cell_ctl_t         q_ctl;

	assign restart = cfg_we
		&& ((cfg_index == cca_pkg::CFG_WIDTH) || (cfg_index == cca_pkg::CFG_HEIGHT));

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			birth_q    <= cca_pkg::BIRTH_RST;
			survival_q <= cca_pkg::SURVIVAL_RST;
			width_q    <= SWX'(W_RST);
			height_q   <= SWY'(H_RST);
		end else if (cfg_we) begin
			unique case (cfg_index)
				cca_pkg::CFG_BIRTH: begin
					birth_q <= cfg_data[cca_pkg::MASK_W-1:0];
				end
				cca_pkg::CFG_SURVIVAL: begin
					survival_q <= cfg_data[cca_pkg::MASK_W-1:0];
				end
				cca_pkg::CFG_WIDTH: begin
					width_q <= SWX'(cca_pkg::clamp_size(cfg_data, MAX_WIDTH));
				end
				cca_pkg::CFG_HEIGHT: begin
					height_q <= SWY'(cca_pkg::clamp_size(cfg_data, MAX_HEIGHT));
				end
				default: begin
				end
			endcase
		end
	end

	cca_front #(
		.XW (XW),
		.YW (YW),
		.SWX(SWX),
		.SWY(SWY)
	) u_front (
		.clk     (clk),
		.arst_n  (arst_n),
		.grid    (grid),
		.restart (restart),
		.width   (width_q),
		.height  (height_q),
		.full    (q_full),
		.push    (push),
		.push_x  (push_x),
		.push_y  (push_y),
		.push_ctl(push_ctl)
	);

	cca_queue #(
		.DATA_W(QW)
	) u_queue (
		.clk      (clk),
		.arst_n   (arst_n),
		.push     (push),
		.push_data({push_ctl, push_x, push_y}),
		.full     (q_full),
		.pop      (q_pop),
		.pop_data (q_data),
		.empty    (q_empty)
	);

	assign {q_ctl, q_x, q_y} = q_data;

	cca_back #(
		.MAX_WIDTH(MAX_WIDTH),
		.XW       (XW),
		.YW       (YW)
	) u_back (
		.clk          (clk),
		.arst_n       (arst_n),
		.restart      (restart),
		.birth_mask   (birth_q),
		.survival_mask(survival_q),
		.q_valid      (!q_empty),
		.q_x          (q_x),
		.q_y          (q_y),
		.q_ctl        (q_ctl),
		.pop          (q_pop),
		.result       (result)
	);

endmodule

`default_nettype wire
